@@ rtl/lsnc_pkg.sv @@
// Package for the spline network classifier: payload structs, command codes,
// controller states and the sigmoid knot table. No dependencies.
package lsnc_pkg;

  localparam int unsigned EdgesDef    = 16;
  localparam int unsigned SegmentsDef = 8;
  localparam int unsigned SamplesDef  = 16;
  localparam int unsigned SampleDepth = 2048;
  localparam int unsigned SegDepth    = 128;
  localparam int unsigned CfgIdxW     = 2;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_FEATURE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_SEG_RATE  = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [10:0]        table_index;
    logic [7:0]         quant_sample;
    logic signed [15:0] seg_offset;
    logic [15:0]        seg_scale;
    logic signed [15:0] feature;
  } in_item_t;

  typedef struct packed {
    logic               decision;
    logic signed [31:0] logit;
    logic [15:0]        probability;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_SEG,
    ST_FRAC,
    ST_READ,
    ST_DEQ0,
    ST_DEQ1,
    ST_MIX0,
    ST_MIX1,
    ST_ACC,
    ST_SIG,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pos;
    logic seg;
    logic frac;
    logic rd;
    logic deq0;
    logic deq1;
    logic mix0;
    logic mix1;
    logic acc;
    logic sig;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic last_edge;
    logic out_busy;
  } stat_t;

  function automatic logic [15:0] sig_knot(input logic [3:0] n);
    logic [15:0] k;
    unique case (n)
      4'd0: k = 16'd32768;
      4'd1: k = 16'd47911;
      4'd2: k = 16'd57724;
      4'd3: k = 16'd62428;
      4'd4: k = 16'd64357;
      4'd5: k = 16'd65097;
      4'd6: k = 16'd65374;
      4'd7: k = 16'd65476;
      default: k = 16'd65514;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/lut_spline_network_classifier.sv @@
// Spline network classifier top level: controller plus datapath.
// Load items are taken while idle. A feature runs the shared step sequence;
// the last feature of a group adds the sigmoid and output hand-off states,
// which wait while an earlier result is still stalled at the output.
// The result is registered in the output hand-off state after the last feature; one item in flight.
// Reset (async, active low) clears the accumulator, edge count and registers
// to defaults; the stores hold undefined data until written.
module lut_spline_network_classifier #(
  parameter int unsigned Edges    = lsnc_pkg::EdgesDef,
  parameter int unsigned Segments = lsnc_pkg::SegmentsDef,
  parameter int unsigned Samples  = lsnc_pkg::SamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsnc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsnc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [lsnc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import lsnc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lsnc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i,
    .in_cmd_i (cmd_e'(in_data_i.cmd)),
    .stat_i   (stat),
    .in_stall_o,
    .ctrl_o   (ctrl)
  );

  lsnc_datapath #(.Edges(Edges), .Segments(Segments), .Samples(Samples)) u_dp (
    .clk_i, .rst_ni, .in_data_i,
    .ctrl_i (ctrl),
    .stat_o (stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

@@ rtl/lsnc_ctrl.sv @@
// Controller state machine of the spline network classifier.
// Depends on lsnc_pkg.
module lsnc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  lsnc_pkg::cmd_e  in_cmd_i,
  input  lsnc_pkg::stat_t stat_i,
  output logic            in_stall_o,
  output lsnc_pkg::ctrl_t ctrl_o
);
  import lsnc_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take && in_cmd_i == CMD_FEATURE) state_d = ST_POS;
      ST_POS:  state_d = ST_SEG;
      ST_SEG:  state_d = ST_FRAC;
      ST_FRAC: state_d = ST_READ;
      ST_READ: state_d = ST_DEQ0;
      ST_DEQ0: state_d = ST_DEQ1;
      ST_DEQ1: state_d = ST_MIX0;
      ST_MIX0: state_d = ST_MIX1;
      ST_MIX1: state_d = ST_ACC;
      ST_ACC:  state_d = stat_i.last_edge ? ST_SIG : ST_IDLE;
      // The output register is only refilled once the previous result has left.
      ST_SIG:  if (!stat_i.out_busy) state_d = ST_OUT;
      ST_OUT:  if (!stat_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.load = take;
    unique case (state_q)
      ST_POS:  ctrl_o.pos  = 1'b1;
      ST_SEG:  ctrl_o.seg  = 1'b1;
      ST_FRAC: ctrl_o.frac = 1'b1;
      ST_READ: ctrl_o.rd   = 1'b1;
      ST_DEQ0: ctrl_o.deq0 = 1'b1;
      ST_DEQ1: ctrl_o.deq1 = 1'b1;
      ST_MIX0: ctrl_o.mix0 = 1'b1;
      ST_MIX1: ctrl_o.mix1 = 1'b1;
      ST_ACC:  ctrl_o.acc  = 1'b1;
      ST_SIG:  ctrl_o.sig  = !stat_i.out_busy;
      ST_OUT:  ctrl_o.emit = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

@@ rtl/lsnc_datapath.sv @@
// Datapath of the spline network classifier: stores, configuration registers,
// multipliers, accumulator, sigmoid and output register. Uses lsnc_pkg.
module lsnc_datapath #(
  parameter int unsigned Edges    = lsnc_pkg::EdgesDef,
  parameter int unsigned Segments = lsnc_pkg::SegmentsDef,
  parameter int unsigned Samples  = lsnc_pkg::SamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsnc_pkg::in_item_t  in_data_i,
  input  lsnc_pkg::ctrl_t     ctrl_i,
  output lsnc_pkg::stat_t     stat_o,
  input  logic                cfg_we_i,
  input  logic [lsnc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsnc_pkg::out_item_t out_data_o
);
  import lsnc_pkg::*;

  localparam int unsigned EdgeW = (Edges > 1) ? $clog2(Edges) : 1;

  logic [7:0]  sample_mem [SampleDepth];
  logic [15:0] off_mem [SegDepth];
  logic [15:0] scl_mem [SegDepth];

  logic signed [15:0] rmin_q, rmax_q;
  logic [15:0]        rate_q;
  logic signed [31:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= -16'sd4096;
      rmax_q <= 16'sd4096;
      rate_q <= 16'd1024;
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_RANGE_MIN: rmin_q <= cfg_data_i[15:0];
        REG_RANGE_MAX: rmax_q <= cfg_data_i[15:0];
        REG_SEG_RATE:  rate_q <= cfg_data_i[15:0];
        REG_THRESHOLD: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && cmd_e'(in_data_i.cmd) == CMD_SAMPLE) begin
      sample_mem[in_data_i.table_index] <= in_data_i.quant_sample;
    end
    if (ctrl_i.load && cmd_e'(in_data_i.cmd) == CMD_SEGMENT) begin
      off_mem[in_data_i.table_index[6:0]] <= in_data_i.seg_offset;
      scl_mem[in_data_i.table_index[6:0]] <= in_data_i.seg_scale;
    end
  end

  // Clamp and offset in the position step; d is nonnegative and below 2^17.
  logic signed [17:0] x_q, hi_c, xc_c;
  logic [16:0]        d_q;
  logic               dpos_q;
  assign hi_c = 18'(rmax_q) - 18'sd1;
  always_comb begin
    if (x_q < 18'(rmin_q))  xc_c = 18'(rmin_q);
    else if (x_q > hi_c)    xc_c = hi_c;
    else                    xc_c = x_q;
  end

  logic [32:0] t_q;
  logic [20:0] u_q;
  logic [5:0]  seg_q;
  logic [26:0] pos_c;
  logic [5:0]  r0_q, r1_q;
  logic [19:0] w_q;
  logic [10:0] base_c;
  logic [7:0]  s0_q, s1_q;
  logic signed [15:0] off_q;
  logic [15:0] scl_q;
  logic signed [25:0] y0_q, y1_q;
  logic signed [47:0] m0_q;
  logic signed [48:0] acc_c;
  logic signed [31:0] sum_q;
  logic [EdgeW-1:0]   cnt_q;
  logic [32:0] tseg_c;
  logic [5:0]  r0_c;
  logic [63:0] ev_c;
  logic signed [39:0] ev_s;
  logic signed [40:0] s_c;

  assign tseg_c = t_q >> 20;
  assign pos_c  = 27'(u_q) * 27'(Samples - 1);
  assign r0_c   = (pos_c[26:20] > 7'(Samples - 1)) ? 6'(Samples - 1) : pos_c[25:20];
  assign base_c = 11'(cnt_q) * 11'(Segments) + 11'(seg_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) x_q <= 18'(in_data_i.feature);
    if (ctrl_i.pos) begin
      d_q    <= 17'(xc_c - 18'(rmin_q));
      dpos_q <= (xc_c > 18'(rmin_q));
    end
    if (ctrl_i.seg) t_q <= 33'(d_q) * 33'(rate_q);
    if (ctrl_i.frac) begin
      if (!dpos_q) begin
        seg_q <= '0;
        u_q   <= '0;
      end else if (tseg_c > 33'(Segments - 1)) begin
        seg_q <= 6'(Segments - 1);
        u_q   <= ((t_q - (33'(Segments - 1) << 20)) > 33'(1 << 20)) ? 21'(1 << 20)
                 : 21'(t_q - (33'(Segments - 1) << 20));
      end else begin
        seg_q <= 6'(tseg_c);
        u_q   <= 21'(t_q[19:0]);
      end
    end
    if (ctrl_i.rd) begin
      r0_q  <= r0_c;
      r1_q  <= (7'(r0_c) + 7'd1 > 7'(Samples - 1)) ? 6'(Samples - 1) : r0_c + 6'd1;
      w_q   <= 20'(pos_c - (27'(r0_c) << 20));
      off_q <= off_mem[base_c[6:0]];
      scl_q <= scl_mem[base_c[6:0]];
    end
    if (ctrl_i.deq0) begin
      s0_q <= sample_mem[11'(base_c * 11'(Samples)) + 11'(r0_q)];
      s1_q <= sample_mem[11'(base_c * 11'(Samples)) + 11'(r1_q)];
    end
    if (ctrl_i.deq1) begin
      y0_q <= 26'(off_q) * 26'sd16 + $signed({2'd0, 24'(scl_q) * 24'(s0_q)});
      y1_q <= 26'(off_q) * 26'sd16 + $signed({2'd0, 24'(scl_q) * 24'(s1_q)});
    end
    if (ctrl_i.mix0) m0_q <= 48'(y0_q) * $signed({1'b0, 21'(21'(1 << 20) - 21'(w_q))});
  end

  logic signed [48:0] m1_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix1) m1_q <= 49'(y1_q) * $signed({29'd0, w_q});
  end
  assign acc_c = 49'(m0_q) + m1_q;
  assign ev_c  = 64'(acc_c) + 64'(1 << 23);
  assign ev_s  = 40'($signed(ev_c) >>> 24);
  assign s_c   = 41'(sum_q) + 41'(ev_s);

  // Sigmoid of the final logit.
  logic [31:0] a_c;
  logic [16:0] p_c, pk_c;
  logic [15:0] klo, khi;
  logic [37:0] tail_c;
  logic [7:0]  tdiv_c;
  logic [17:0] tq_c;
  assign a_c  = sum_q[31] ? 32'(-33'(sum_q)) : sum_q;
  assign klo  = sig_knot(a_c[15:12]);
  assign khi  = sig_knot(a_c[15:12] + 4'd1);
  assign tail_c = (38'(a_c) - 38'd32768) * 38'd22 + 38'd45056;
  // The tail divisor is 11 * 2^13: drop 13 bits, then multiply by 745 / 8192,
  // which is an exact division by 11 for every value below 248.
  assign tdiv_c = tail_c[20:13];
  assign tq_c   = 18'(tdiv_c) * 18'd745;
  always_comb begin
    if (a_c >= 32'd32768) pk_c = 17'd65514 + 17'(tq_c[17:13]);
    else pk_c = 17'(klo) + 17'((28'(khi - klo) * 28'(a_c[11:0]) + 28'd2048) >> 12);
    p_c = sum_q[31] ? 17'd65536 - pk_c : pk_c;
  end

  logic        ov_q;
  out_item_t   od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) ov_q <= 1'b0;
      if (ctrl_i.acc) begin
        if (s_c > 41'sd2147483647) sum_q <= 32'sh7fffffff;
        else if (s_c < -41'sd2147483648) sum_q <= 32'sh80000000;
        else sum_q <= 32'(s_c);
        cnt_q <= (32'(cnt_q) == Edges - 1) ? '0 : cnt_q + 1'b1;
      end
      if (ctrl_i.emit) begin
        ov_q  <= 1'b1;
        sum_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sig) begin
      od_q.decision <= (sum_q >= thr_q);
      od_q.logit    <= sum_q;
      if (sum_q > 32'sd122880) od_q.probability <= 16'hffff;
      else if (sum_q < -32'sd122880) od_q.probability <= '0;
      else od_q.probability <= (p_c > 17'd65535) ? 16'hffff : p_c[15:0];
    end
  end

  assign stat_o.last_edge = (32'(cnt_q) == Edges - 1);
  assign stat_o.out_busy  = ov_q && out_stall_i;
  assign out_valid_o      = ov_q;
  assign out_data_o       = od_q;

endmodule

@@ rtl/lsnc_checker.sv @@
// Port checker for the spline network classifier, bound to the top level.
// Depends on lsnc_pkg.
module lsnc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lsnc_pkg::out_item_t out_data_o
);
  import lsnc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // A result never appears in the cycle right after an input transaction.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after an input transaction");

  a_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.logit > 32'sd122880 |-> out_data_o.probability == 16'hffff)
    else $error("probability not saturated");

  a_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.logit < -32'sd122880 |-> out_data_o.probability == 16'd0)
    else $error("probability not zero");

endmodule

bind lut_spline_network_classifier lsnc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
